### sv/hdep_pkg.sv
// Shared types and constants for the HTTP date to epoch parser.
// Holds the parse phase encoding, the record passed from parser to converter,
// and the month and day-of-year tables. No dependencies.
`default_nettype none

package hdep_pkg;

	// Character codes used by the parser.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam int YEAR_W  = 14;   // year value, at most 9999
	localparam int FIELD_W = 7;    // day, hour, minute, second, at most 99
	localparam int MONTH_W = 4;    // month number, 1 to 12
	localparam int EPOCH_W = 39;
	localparam int DAYS_W  = 24;
	localparam int HMS_W   = 19;
	localparam int Q_DEPTH = 2;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
	localparam logic [YEAR_W-1:0] ERA_SHIFT = 14'd400;
	localparam logic [DAYS_W-1:0] DAYS_BIAS = 24'd865565;  // 146097 + 719468
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;
	localparam logic [12:0] RECIP_100 = 13'd5243;  // floor(x/100) = (x*5243) >> 19 for x < 2^14
	localparam int RECIP_SHIFT = 19;

	typedef enum logic [14:0] {
		PH_LEAD    = 15'h0001,
		PH_WDAY    = 15'h0002,
		PH_SKIP_D  = 15'h0004,
		PH_DAY     = 15'h0008,
		PH_SKIP_M  = 15'h0010,
		PH_MON     = 15'h0020,
		PH_SKIP_Y  = 15'h0040,
		PH_YEAR    = 15'h0080,
		PH_SKIP_H  = 15'h0100,
		PH_HOUR    = 15'h0200,
		PH_SKIP_MI = 15'h0400,
		PH_MIN     = 15'h0800,
		PH_SKIP_S  = 15'h1000,
		PH_SEC     = 15'h2000,
		PH_DONE    = 15'h4000
	} phase_t;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_SUM  = 4'b0010,
		B_MUL  = 4'b0100,
		B_OUT  = 4'b1000
	} back_state_t;

	// One parsed date, handed from the parser to the converter.
	typedef struct packed {
		logic               valid;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
	} rec_t;

	localparam logic [23:0] MONTH_NAMES [12] = '{
		24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
		24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
	};

	function automatic logic [MONTH_W-1:0] month_code(input logic [23:0] name);
		logic [MONTH_W-1:0] code;
		code = '0;
		for (int i = 0; i < 12; i++) begin
			if (MONTH_NAMES[i] == name)
				code = MONTH_W'(i + 1);
		end
		return code;
	endfunction

	// Days from March 1st to the first of the month, months counted from March.
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] off;
		case (mp)
			4'd0:    off = 9'd0;
			4'd1:    off = 9'd31;
			4'd2:    off = 9'd61;
			4'd3:    off = 9'd92;
			4'd4:    off = 9'd122;
			4'd5:    off = 9'd153;
			4'd6:    off = 9'd184;
			4'd7:    off = 9'd214;
			4'd8:    off = 9'd245;
			4'd9:    off = 9'd275;
			4'd10:   off = 9'd306;
			4'd11:   off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

`default_nettype wire

### sv/hdep_front.sv
// Character parser: walks the date text one item per cycle while q_full is low and
// emits one record per header on its final character. Depends on hdep_pkg.
`default_nettype none

module hdep_front #(
	parameter int YEAR_DIGITS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [7:0]         in_char,
	input  wire logic               in_last,
	input  wire logic               q_full,
	output logic                    in_ready,
	output logic                    push,
	output hdep_pkg::rec_t          push_rec
);
	import hdep_pkg::*;

	localparam int ACC_W = $clog2(10 ** YEAR_DIGITS);
	localparam int CNT_W = $clog2(YEAR_DIGITS + 1);

	phase_t             phase_q, ph_n;
	logic [ACC_W-1:0]   acc_q, acc_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [FIELD_W-1:0] day_q, day_n, hour_q, hour_n, min_q, min_n, sec_q, sec_n;
	logic [15:0]        let_q, let_n;
	logic [MONTH_W-1:0] mon_q, mon_n, mon_match;
	logic [YEAR_W-1:0]  year_q, year_n;
	logic               err_q, err_n;
	logic               ws, dg, accept;
	logic [3:0]         dig;
	logic [ACC_W+3:0]   acc_add;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign ws  = (in_char == CH_SPACE) || (in_char >= CH_TAB && in_char <= CH_CR);
	assign dg  = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
	assign dig = in_char[3:0];
	assign acc_add = (ACC_W+4)'(acc_q) * (ACC_W+4)'(10) + (ACC_W+4)'(dig);
	assign mon_match = month_code({let_q, in_char});

	always_comb begin
		ph_n   = phase_q;
		acc_n  = acc_q;
		cnt_n  = cnt_q;
		day_n  = day_q;
		let_n  = let_q;
		mon_n  = mon_q;
		year_n = year_q;
		hour_n = hour_q;
		min_n  = min_q;
		sec_n  = sec_q;
		err_n  = err_q;
		if (!err_q) begin
			unique case (phase_q)
				PH_LEAD: begin
					if (!ws) begin
						cnt_n = CNT_W'(1);
						ph_n  = PH_WDAY;
					end
				end
				PH_WDAY: begin
					if (ws)
						ph_n = PH_SKIP_D;
					else if (cnt_q < CNT_W'(3))
						cnt_n = cnt_q + CNT_W'(1);
					else if (in_char == CH_COMMA)
						ph_n = PH_SKIP_D;
					else
						err_n = 1'b1;
				end
				PH_SKIP_D, PH_SKIP_Y, PH_SKIP_H, PH_SKIP_MI, PH_SKIP_S: begin
					if (dg) begin
						acc_n = ACC_W'(dig);
						cnt_n = CNT_W'(1);
						case (phase_q)
							PH_SKIP_D:  ph_n = PH_DAY;
							PH_SKIP_Y:  ph_n = PH_YEAR;
							PH_SKIP_H:  ph_n = PH_HOUR;
							PH_SKIP_MI: ph_n = PH_MIN;
							default:    ph_n = PH_SEC;
						endcase
					end else if (!ws) begin
						err_n = 1'b1;
					end
				end
				PH_SKIP_M: begin
					if (!ws) begin
						let_n = {8'h00, in_char};
						cnt_n = CNT_W'(1);
						ph_n  = PH_MON;
					end
				end
				PH_MON: begin
					if (ws) begin
						err_n = 1'b1;
					end else if (cnt_q == CNT_W'(1)) begin
						let_n = {let_q[7:0], in_char};
						cnt_n = CNT_W'(2);
					end else begin
						mon_n = mon_match;
						if (mon_match == '0)
							err_n = 1'b1;
						else
							ph_n = PH_SKIP_Y;
					end
				end
				PH_YEAR: begin
					if (dg) begin
						if (cnt_q >= CNT_W'(YEAR_DIGITS)) begin
							err_n = 1'b1;
						end else begin
							acc_n = acc_add[ACC_W-1:0];
							cnt_n = cnt_q + CNT_W'(1);
						end
					end else if (ws && (ACC_W+1)'(acc_q) <= (ACC_W+1)'(YEAR_MAX)) begin
						year_n = acc_q[YEAR_W-1:0];
						ph_n   = PH_SKIP_H;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_DAY, PH_HOUR, PH_MIN, PH_SEC: begin
					if (dg) begin
						if (cnt_q >= CNT_W'(2)) begin
							err_n = 1'b1;
						end else begin
							acc_n = acc_add[ACC_W-1:0];
							cnt_n = cnt_q + CNT_W'(1);
						end
					end else begin
						case (phase_q)
							PH_DAY: begin
								day_n = acc_q[FIELD_W-1:0];
								if (ws) begin
									ph_n = PH_SKIP_M;
								end else begin
									let_n = {8'h00, in_char};
									cnt_n = CNT_W'(1);
									ph_n  = PH_MON;
								end
							end
							PH_HOUR: begin
								if (in_char == CH_COLON) begin
									hour_n = acc_q[FIELD_W-1:0];
									ph_n   = PH_SKIP_MI;
								end else begin
									err_n = 1'b1;
								end
							end
							PH_MIN: begin
								if (in_char == CH_COLON) begin
									min_n = acc_q[FIELD_W-1:0];
									ph_n  = PH_SKIP_S;
								end else begin
									err_n = 1'b1;
								end
							end
							default: begin
								sec_n = acc_q[FIELD_W-1:0];
								ph_n  = PH_DONE;
							end
						endcase
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// The final character may still be inside the seconds digits.
	always_comb begin
		push            = accept && in_last;
		push_rec.valid  = !err_n && (ph_n == PH_SEC || ph_n == PH_DONE);
		push_rec.year   = year_n;
		push_rec.month  = mon_n;
		push_rec.day    = day_n;
		push_rec.hour   = hour_n;
		push_rec.minute = min_n;
		push_rec.second = (ph_n == PH_SEC) ? acc_n[FIELD_W-1:0] : sec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			cnt_q   <= '0;
			day_q   <= '0;
			let_q   <= '0;
			mon_q   <= '0;
			year_q  <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= PH_LEAD;
				acc_q   <= '0;
				cnt_q   <= '0;
				day_q   <= '0;
				let_q   <= '0;
				mon_q   <= '0;
				year_q  <= '0;
				hour_q  <= '0;
				min_q   <= '0;
				sec_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= ph_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
				day_q   <= day_n;
				let_q   <= let_n;
				mon_q   <= mon_n;
				year_q  <= year_n;
				hour_q  <= hour_n;
				min_q   <= min_n;
				sec_q   <= sec_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

### sv/hdep_fifo.sv
// Short record queue between the parser and the converter.
// Depends on hdep_pkg for the record type and depth.
`default_nettype none

module hdep_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hdep_pkg::rec_t push_rec,
	input  wire logic           pop,
	output hdep_pkg::rec_t      head,
	output logic                full,
	output logic                empty
);
	import hdep_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	rec_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### sv/hdep_conv.sv
// Converter: turns one parsed date into Unix seconds in registered steps
// (days-from-civil terms, then day sum, then scale) and holds it for the output.
// Depends on hdep_pkg.
`default_nettype none

module hdep_conv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire hdep_pkg::rec_t              head,
	input  wire logic                        empty,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             out_date_valid,
	output logic [hdep_pkg::EPOCH_W-1:0]     out_epoch
);
	import hdep_pkg::*;

	back_state_t        state_q;
	logic [YEAR_W-1:0]  yy;
	logic [3:0]         mp;
	logic [26:0]        q100_prod;

	logic [YEAR_W-1:0]  yy_s1;
	logic [22:0]        p365_s1;
	logic [7:0]         q100_s1;
	logic [8:0]         off_s1;
	logic [FIELD_W-1:0] day_s1, sec_s1;
	logic [18:0]        h3600_s1;
	logic [12:0]        m60_s1;
	logic               vld_s1;

	logic [DAYS_W-1:0]  days_s2;
	logic [HMS_W-1:0]   hms_s2;
	logic               vld_s2;

	logic signed [41:0] ep_full;
	logic               valid_q;
	logic [EPOCH_W-1:0] epoch_q;

	// Shift the year by one 400-year era so that January and February stay positive.
	assign yy = head.year + ERA_SHIFT - ((head.month <= MONTH_W'(2)) ? YEAR_W'(1) : YEAR_W'(0));
	assign mp = (head.month > MONTH_W'(2)) ? head.month - MONTH_W'(3) : head.month + MONTH_W'(9);
	assign q100_prod = 27'(yy) * 27'(RECIP_100);

	assign pop = (state_q == B_IDLE) && !empty;
	assign ep_full = $signed(days_s2) * $signed({1'b0, SEC_PER_DAY})
	               + $signed({23'b0, hms_s2});

	assign out_valid      = (state_q == B_OUT);
	assign out_date_valid = valid_q;
	assign out_epoch      = epoch_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			yy_s1    <= yy;
			p365_s1  <= 23'(yy) * 23'd365;
			q100_s1  <= q100_prod[RECIP_SHIFT+7:RECIP_SHIFT];
			off_s1   <= month_offset(mp);
			day_s1   <= head.day;
			sec_s1   <= head.second;
			h3600_s1 <= 19'(head.hour) * 19'(SEC_PER_HOUR);
			m60_s1   <= 13'(head.minute) * 13'(SEC_PER_MIN);
			vld_s1   <= head.valid;
		end
		if (state_q == B_SUM) begin
			days_s2 <= DAYS_W'(p365_s1) + DAYS_W'(yy_s1 >> 2) - DAYS_W'(q100_s1)
			         + DAYS_W'(q100_s1 >> 2) + DAYS_W'(off_s1) + DAYS_W'(day_s1)
			         - DAYS_W'(1) - DAYS_BIAS;
			hms_s2  <= HMS_W'(h3600_s1) + HMS_W'(m60_s1) + HMS_W'(sec_s1);
			vld_s2  <= vld_s1;
		end
		if (state_q == B_MUL) begin
			valid_q <= vld_s2;
			epoch_q <= vld_s2 ? ep_full[EPOCH_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE:  if (!empty) state_q <= B_SUM;
				B_SUM:   state_q <= B_MUL;
				B_MUL:   state_q <= B_OUT;
				B_OUT:   if (out_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/http_date_to_epoch_parser_unit.sv
// Channel | dir | tdata                          | tuser          | tlast
// s_axis  | in  | [7:0] char_code                | -              | last_char
// m_axis  | out | [38:0] epoch_seconds, [39] 0   | [0] date_valid | -
//
// The parser takes one character item per cycle; its ready drops only while the
// two-entry record queue is full. The converter carries each date from the queue head
// through the stage-1, sum and multiply registers to the output register and holds
// it there until m_axis_tready, taking no new date until then. m_axis_tvalid rises
// once the date has passed these registers, later if an earlier date still holds them.
// Reset is asynchronous and returns the parser to skipping leading whitespace.
// Top level: instantiates hdep_front, hdep_fifo and hdep_conv; uses hdep_pkg.
`default_nettype none

module http_date_to_epoch_parser_unit #(
	parameter int YEAR_DIGITS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
	output logic [0:0]       m_axis_tuser    // [0] date_valid
);
	import hdep_pkg::*;

	rec_t               push_rec, head;
	logic               push, pop, full, empty, date_valid;
	logic [EPOCH_W-1:0] epoch;

	hdep_front #(.YEAR_DIGITS(YEAR_DIGITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_char  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (full),
		.in_ready (s_axis_tready),
		.push     (push),
		.push_rec (push_rec)
	);

	hdep_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	hdep_conv u_conv (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_date_valid (date_valid),
		.out_epoch      (epoch)
	);

	assign m_axis_tdata = {1'b0, epoch};
	assign m_axis_tuser = date_valid;

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("record pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("record popped from an empty queue");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("invalid date carries nonzero seconds");

	a_pop_starts_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> ##3 m_axis_tvalid)
		else $error("converter did not present a result three cycles after pop");

endmodule

`default_nettype wire
